>>> design/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg: DNS name label encoder shared definitions
// Byte constants, case folding, and the command and status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] UPPER_LO   = 8'h41;
  localparam logic [7:0] UPPER_HI   = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic take;       // accept one input beat
    logic load_len;   // load length byte into output register, rewind read index
    logic load_byte;  // load buffered byte into output register
    logic inc_idx;    // advance read index
    logic clr_label;  // clear count and overflow flag
  } dnle_cmd_t;

  typedef struct packed {
    logic in_dot;     // input beat is a dot
    logic in_end;     // input beat ends the name
    logic out_free;   // output register can take a beat this cycle
    logic cnt_zero;   // no characters buffered
    logic idx_last;   // read index points at final buffered character
  } dnle_sts_t;

  function automatic byte_t lower_ascii(input byte_t c);
    byte_t r;
    r = c;
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

>>> design/dnle_in_if.sv
// ----------------------------------------------------------------------------
// dnle_in_if: character input channel
// Valid/ready channel carrying one name character and its end mark.
// ----------------------------------------------------------------------------
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_name;

  modport source (output valid, output character, output end_of_name, input ready);
  modport sink   (input valid, input character, input end_of_name, output ready);
endinterface

>>> design/dnle_out_if.sv
// ----------------------------------------------------------------------------
// dnle_out_if: encoded byte output channel
// Valid/ready channel carrying one wire-form byte with its flags.
// ----------------------------------------------------------------------------
interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       label_too_long;

  modport source (output valid, output out_byte, output last, output label_too_long,
                  input ready);
  modport sink   (input valid, input out_byte, input last, input label_too_long,
                  output ready);
endinterface

>>> design/dnle_datapath.sv
// ----------------------------------------------------------------------------
// dnle_datapath: label buffer and output register
// Holds the label store, character count, overflow flag, read index with
// registered read data, and the output beat register.
// ----------------------------------------------------------------------------
module dnle_datapath #(
  parameter int MAX_LABEL = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dnle_pkg::dnle_cmd_t cmd_i,
  output dnle_pkg::dnle_sts_t sts_o,
  input  logic [7:0]          character_i,
  input  logic                end_of_name_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                last_o,
  output logic                label_too_long_o
);
  import dnle_pkg::*;

  localparam int CntW = $clog2(MAX_LABEL + 1);
  localparam int IdxW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  byte_t            store_q [MAX_LABEL];
  logic [CntW-1:0]  count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             end_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  byte_t            rd_q;
  logic             out_valid_q, out_valid_d;
  byte_t            out_byte_q;
  logic             last_q;
  logic             err_q;
  logic             store_en;
  logic             idx_last;

  assign store_en = cmd_i.take && (character_i != DOT_CHAR) && (count_q < CntW'(MAX_LABEL));
  assign idx_last = (CntW'(idx_q) + CntW'(1)) == count_q;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.clr_label) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.take && character_i != DOT_CHAR) begin
      if (store_en) begin
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_len) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_len || cmd_i.load_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // label store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      store_q[count_q[IdxW-1:0]] <= lower_ascii(character_i);
    end
    rd_q <= store_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      end_q <= end_of_name_i;
    end
    if (cmd_i.load_len) begin
      out_byte_q <= 8'(count_q);
      last_q     <= end_q && (count_q == '0);
      err_q      <= ovf_q;
    end else if (cmd_i.load_byte) begin
      out_byte_q <= rd_q;
      last_q     <= end_q && idx_last;
      err_q      <= ovf_q;
    end
  end

  assign sts_o.in_dot   = (character_i == DOT_CHAR);
  assign sts_o.in_end   = end_of_name_i;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.cnt_zero = (count_q == '0);
  assign sts_o.idx_last = idx_last;

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_o           = last_q;
  assign label_too_long_o = err_q;

endmodule

>>> design/dnle_ctrl.sv
// ----------------------------------------------------------------------------
// dnle_ctrl: label encoder sequencer
// Accepts characters while idle and, on a dot or end of name, walks the
// flush: length byte, then each buffered byte via the registered read.
// ----------------------------------------------------------------------------
module dnle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dnle_pkg::dnle_sts_t sts_i,
  output dnle_pkg::dnle_cmd_t cmd_o
);
  import dnle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_FETCH,
    ST_SEND
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.in_dot || sts_i.in_end) begin
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (sts_i.out_free) begin
          cmd_o.load_len = 1'b1;
          if (sts_i.cnt_zero) begin
            cmd_o.clr_label = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clr_label = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.inc_idx = 1'b1;
            state_d       = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/dns_name_label_encoder_core.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core: DNS name label encoder
// Turns a dotted host name, one character per beat, into length-prefixed
// lower-case labels, flagging the last byte and truncated labels.
//
//   channel  dir  beat contents
//   in_ch    in   character, end_of_name
//   out_ch   out  out_byte, last, label_too_long
//
// An ordinary character is taken while idle and the encoder stays idle. A dot
// or end of name is taken, then the label drains: the length byte, then each
// buffered character through a fetch and a send state, set by the registered
// label store read. Reset clears the sequencer, count, overflow flag and
// output valid; the label store is not cleared. A stalled output beat holds
// and the flush waits; input ready stays low for the whole flush.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core #(
  parameter int MAX_LABEL = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dnle_in_if.sink    in_ch,
  dnle_out_if.source out_ch
);
  import dnle_pkg::*;

  dnle_cmd_t cmd;
  dnle_sts_t sts;

  dnle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dnle_datapath #(
    .MAX_LABEL (MAX_LABEL)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .character_i      (in_ch.character),
    .end_of_name_i    (in_ch.end_of_name),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_byte_o       (out_ch.out_byte),
    .last_o           (out_ch.last),
    .label_too_long_o (out_ch.label_too_long)
  );

  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && (sts.in_dot || sts.in_end)) |=> !in_ch.ready)
    else $error("input ready during label flush");

  a_plain_char_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && !sts.in_dot && !sts.in_end) |=> in_ch.ready)
    else $error("ordinary character did not return to idle");

  a_load_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_len || cmd.load_byte) |-> sts.out_free)
    else $error("output register overwritten");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: DNS name label encoder testbench
// Feeds dotted host names one character per beat and keeps its own copy of
// the label buffer to build the expected wire-form bytes. Every output beat
// is checked against the oldest expected byte. The names start with directed
// corner cases, then random labels of many lengths, some over the limit,
// mixed with raw byte noise. Both sides stall at random, with one stretch
// that has no stalls.
// ----------------------------------------------------------------------------
module tb;
  import dnle_pkg::*;

  localparam int LABEL_MAX = 63;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    byte_t ch;
    logic  eon;
  } name_beat_t;

  typedef struct packed {
    byte_t b;
    logic  last;
    logic  too_long;
  } wire_byte_t;

  logic clk_i;
  logic rst_ni;

  dnle_in_if  in_ch();
  dnle_out_if out_ch();

  dns_name_label_encoder_core #(
    .MAX_LABEL(LABEL_MAX)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  name_beat_t char_queue[$];
  wire_byte_t wire_queue[$];

  byte_t      label_buf[LABEL_MAX];
  int         label_len;
  logic       label_ovf;

  int         fail_cnt;
  int         beats_sent;
  int         bytes_checked;
  int         names_done;
  int         truncated_labels;
  logic       steady;
  name_beat_t drv_beat;
  wire_byte_t got_byte;
  wire_byte_t want_byte;

  assign steady = (beats_sent >= 150) && (beats_sent < 260);

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.character = 8'h00;
    in_ch.end_of_name = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always #6 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Expected wire bytes for one label, emptying the buffer.
  function automatic void flush_label(logic ends_name);
    wire_byte_t w;
    w.b = byte_t'(label_len);
    w.last = ends_name && (label_len == 0);
    w.too_long = label_ovf;
    wire_queue.push_back(w);
    for (int i = 0; i < label_len; i++) begin
      w.b = label_buf[i];
      w.last = ends_name && (i == label_len - 1);
      wire_queue.push_back(w);
    end
    if (label_ovf) truncated_labels++;
    label_len = 0;
    label_ovf = 1'b0;
  endfunction

  function automatic void encode_char(byte_t c, logic eon);
    if (c == DOT_CHAR) begin
      flush_label(eon);
    end else begin
      if (label_len < LABEL_MAX) begin
        label_buf[label_len] = (c >= UPPER_LO && c <= UPPER_HI) ? c + CASE_DELTA : c;
        label_len++;
      end else begin
        label_ovf = 1'b1;
      end
      if (eon) flush_label(1'b1);
    end
  endfunction

  function automatic void queue_char(byte_t c, logic eon);
    name_beat_t nb;
    nb.ch = c;
    nb.eon = eon;
    char_queue.push_back(nb);
  endfunction

  function automatic byte_t pick_label_char();
    byte_t c;
    case ($urandom_range(0, 4))
      0: c = byte_t'($urandom_range(8'h41, 8'h5A));
      1: c = byte_t'($urandom_range(8'h61, 8'h7A));
      2: c = byte_t'($urandom_range(8'h30, 8'h39));
      3: c = 8'h2D;
      default: begin
        c = byte_t'($urandom_range(0, 255));
        if (c == DOT_CHAR) c = 8'h5F;
      end
    endcase
    return c;
  endfunction

  // Build one well-formed name from random labels.
  function automatic void queue_name();
    int n_labels;
    int len;
    int r;
    n_labels = $urandom_range(1, 4);
    for (int l = 0; l < n_labels; l++) begin
      r = $urandom_range(0, 99);
      if (r < 5) len = 0;
      else if (r < 93) len = $urandom_range(1, 12);
      else if (r < 96) len = $urandom_range(62, 64);
      else len = $urandom_range(65, 70);
      for (int i = 0; i < len; i++) begin
        queue_char(pick_label_char(),
                   (l == n_labels - 1) && (i == len - 1) && (len != 0) &&
                   ($urandom_range(0, 1) == 1) ? 1'b1 : 1'b0);
      end
      if (l != n_labels - 1) begin
        queue_char(DOT_CHAR, 1'b0);
      end else if (len == 0 || !char_queue[$].eon) begin
        queue_char(DOT_CHAR, 1'b1);
      end
    end
  endfunction

  function automatic void queue_noise();
    int len;
    byte_t c;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(0, 3) == 0) ? DOT_CHAR : byte_t'($urandom_range(0, 255));
      queue_char(c, ($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0);
    end
  endfunction

  // Source side: hold a beat until taken, then maybe idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.character <= 8'h00;
      in_ch.end_of_name <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (char_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
        drv_beat = char_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.character <= drv_beat.ch;
        in_ch.end_of_name <= drv_beat.eon;
        beats_sent <= beats_sent + 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        encode_char(in_ch.character, in_ch.end_of_name);
      end
      if (out_ch.valid && out_ch.ready) begin
        got_byte.b = out_ch.out_byte;
        got_byte.last = out_ch.last;
        got_byte.too_long = out_ch.label_too_long;
        bytes_checked++;
        if (got_byte.last === 1'b1) names_done++;
        if (wire_queue.size() == 0) begin
          $error("unexpected beat: out_byte %0h last %0b label_too_long %0b",
                 got_byte.b, got_byte.last, got_byte.too_long);
          fail_cnt++;
        end else begin
          want_byte = wire_queue.pop_front();
          if (got_byte.b !== want_byte.b) begin
            $error("out_byte: expected %0h, got %0h", want_byte.b, got_byte.b);
            fail_cnt++;
          end
          if (got_byte.last !== want_byte.last) begin
            $error("last: expected %0b, got %0b", want_byte.last, got_byte.last);
            fail_cnt++;
          end
          if (got_byte.too_long !== want_byte.too_long) begin
            $error("label_too_long: expected %0b, got %0b",
                   want_byte.too_long, got_byte.too_long);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    fail_cnt = 0;
    beats_sent = 0;
    bytes_checked = 0;
    names_done = 0;
    truncated_labels = 0;
    label_len = 0;
    label_ovf = 1'b0;

    // single upper-case letter ending the name
    queue_char(8'h41, 1'b1);
    // case-fold borders and byte extremes in one label
    queue_char(8'h5A, 1'b0);
    queue_char(8'h40, 1'b0);
    queue_char(8'h5B, 1'b0);
    queue_char(8'h60, 1'b0);
    queue_char(8'h7B, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h61, 1'b1);
    // name that is only a dot
    queue_char(DOT_CHAR, 1'b1);
    // leading dot, doubled dot, trailing dot ending the name
    queue_char(DOT_CHAR, 1'b0);
    queue_char(DOT_CHAR, 1'b0);
    queue_char(8'h62, 1'b0);
    queue_char(DOT_CHAR, 1'b1);
    // two labels, last one ended by a character
    queue_char(8'h51, 1'b0);
    queue_char(8'h7A, 1'b0);
    queue_char(DOT_CHAR, 1'b0);
    queue_char(8'h33, 1'b0);
    queue_char(8'h2D, 1'b1);

    while (char_queue.size() < 450) begin
      if ($urandom_range(0, 9) == 0) queue_noise();
      else queue_name();
    end
    queue_char(DOT_CHAR, 1'b1);

    wait (rst_ni === 1'b1);
    wait (char_queue.size() == 0 && in_ch.valid === 1'b0);
    @(posedge clk_i);
    wait (wire_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Encoded %0d names from %0d character beats, %0d wire bytes checked",
             names_done, beats_sent, bytes_checked);
    $display("Truncated labels seen: %0d, failures: %0d", truncated_labels, fail_cnt);
    if (fail_cnt == 0 && wire_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> dns_name_label_encoder_core.f
design/dnle_pkg.sv
design/dnle_in_if.sv
design/dnle_out_if.sv
design/dnle_datapath.sv
design/dnle_ctrl.sv
design/dns_name_label_encoder_core.sv
tb/tb.sv
